@@ design/sgs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the datapath op table for the Gram-Schmidt block.
// No dependencies; every other file refers to it by scoped names.
package sgs_pkg;

    // Fixed formats
    localparam int FRAC_BITS_DEF = 29;              // default fraction bits
    localparam int NORM_GUARD    = 30;              // extra root bits
    localparam int DW            = 32;              // matrix part width
    localparam int MUL_W         = DW + 1;          // multiplier operand
    localparam int SQ_W          = 66;              // exact sum of six squares
    localparam int RT_W          = SQ_W / 2 + NORM_GUARD; // norm root width
    localparam int ACC_W         = 100;             // accumulator width

    typedef struct packed {
        logic signed [31:0] a0_re;
        logic signed [31:0] a0_im;
        logic signed [31:0] a1_re;
        logic signed [31:0] a1_im;
        logic signed [31:0] a2_re;
        logic signed [31:0] a2_im;
        logic signed [31:0] b0_re;
        logic signed [31:0] b0_im;
        logic signed [31:0] b1_re;
        logic signed [31:0] b1_im;
        logic signed [31:0] b2_re;
        logic signed [31:0] b2_im;
    } t_in;

    typedef struct packed {
        logic        [1:0]  column_index;
        logic signed [31:0] r0_re;
        logic signed [31:0] r0_im;
        logic signed [31:0] r1_re;
        logic signed [31:0] r1_im;
        logic signed [31:0] r2_re;
        logic signed [31:0] r2_im;
        logic               last_column;
    } t_out;

    // One column: parts ordered row0 re, row0 im, row1 re, ...
    typedef logic [5:0][31:0] t_col;

    localparam logic [1:0] COL_LAST = 2'd2;

    // Operand sources of the multiplier
    localparam logic [4:0] SRC_C0     = 5'd0;   // c0 part 0..5
    localparam logic [4:0] SRC_C1     = 5'd6;   // c1 part 0..5
    localparam logic [4:0] SRC_DRE_LO = 5'd12;
    localparam logic [4:0] SRC_DRE_HI = 5'd13;
    localparam logic [4:0] SRC_DIM_LO = 5'd14;
    localparam logic [4:0] SRC_DIM_HI = 5'd15;
    localparam logic [4:0] SRC_ONE    = 5'd16;

    // Product alignment
    localparam logic [1:0] SH_0    = 2'd0;
    localparam logic [1:0] SH_32   = 2'd1;
    localparam logic [1:0] SH_FRAC = 2'd2;

    // Writeback targets
    localparam logic [2:0] DST_SUMSQ = 3'd0;
    localparam logic [2:0] DST_DRE   = 3'd1;
    localparam logic [2:0] DST_DIM   = 3'd2;
    localparam logic [2:0] DST_C1    = 3'd3;
    localparam logic [2:0] DST_C2    = 3'd4;

    // Op groups, each ends in one writeback
    localparam logic [3:0] GRP_SQ0  = 4'd0;
    localparam logic [3:0] GRP_DRE  = 4'd1;
    localparam logic [3:0] GRP_DIM  = 4'd2;
    localparam logic [3:0] GRP_PRJ0 = 4'd3;
    localparam logic [3:0] GRP_PRJ5 = 4'd8;
    localparam logic [3:0] GRP_SQ1  = 4'd9;
    localparam logic [3:0] GRP_CRS0 = 4'd10;
    localparam logic [3:0] GRP_LAST = 4'd15;

    typedef struct packed {
        logic [4:0] a_sel;
        logic [4:0] b_sel;
        logic       neg;
        logic [1:0] sh;
        logic [2:0] dst;
        logic [2:0] dst_idx;
    } t_uop;

    // Index of the last op in a group
    function automatic logic [2:0] grp_last_op(input logic [3:0] g);
        logic [2:0] n;
        begin
            if (g <= GRP_DIM || g == GRP_SQ1) begin
                n = 3'd5;
            end else if (g <= GRP_PRJ5) begin
                n = 3'd4;
            end else begin
                n = 3'd3;
            end
            return n;
        end
    endfunction

    // Multiply-accumulate op k of group g
    function automatic t_uop uop_at(input logic [3:0] g, input logic [2:0] k);
        t_uop       u;
        logic [2:0] p;
        logic [1:0] row;
        logic [1:0] j;
        logic [1:0] m;
        logic [4:0] cre, cim;
        logic [4:0] xjre, xjim, xkre, xkim, yjre, yjim, ykre, ykim;
        begin
            u = '0;
            u.sh = SH_0;
            p = '0;
            row = '0;
            j = '0;
            m = '0;
            if (g == GRP_SQ0 || g == GRP_SQ1) begin
                // sum of squares of one column
                u.a_sel = ((g == GRP_SQ0) ? SRC_C0 : SRC_C1) + {2'b0, k};
                u.b_sel = u.a_sel;
                u.dst = DST_SUMSQ;
            end else if (g == GRP_DRE) begin
                u.a_sel = SRC_C0 + {2'b0, k};
                u.b_sel = SRC_C1 + {2'b0, k};
                u.dst = DST_DRE;
            end else if (g == GRP_DIM) begin
                // re*im is added, im*re subtracted
                u.a_sel = SRC_C0 + {2'b0, k};
                u.b_sel = SRC_C1 + {2'b0, k ^ 3'd1};
                u.neg = k[0];
                u.dst = DST_DIM;
            end else if (g <= GRP_PRJ5) begin
                // c1 * 2^F minus c0 * dot, dot split in 32-bit halves
                p = 3'(g - GRP_PRJ0);
                cre = SRC_C0 + {2'b0, p[2:1], 1'b0};
                cim = cre + 5'd1;
                case (k)
                    3'd0: begin
                        u.a_sel = SRC_C1 + {2'b0, p};
                        u.b_sel = SRC_ONE;
                        u.sh = SH_FRAC;
                    end
                    3'd1: begin
                        u.a_sel = cre;
                        u.b_sel = p[0] ? SRC_DIM_LO : SRC_DRE_LO;
                        u.neg = 1'b1;
                    end
                    3'd2: begin
                        u.a_sel = cre;
                        u.b_sel = p[0] ? SRC_DIM_HI : SRC_DRE_HI;
                        u.neg = 1'b1;
                        u.sh = SH_32;
                    end
                    3'd3: begin
                        u.a_sel = cim;
                        u.b_sel = p[0] ? SRC_DRE_LO : SRC_DIM_LO;
                        u.neg = p[0];
                    end
                    default: begin
                        u.a_sel = cim;
                        u.b_sel = p[0] ? SRC_DRE_HI : SRC_DIM_HI;
                        u.neg = p[0];
                        u.sh = SH_32;
                    end
                endcase
                u.dst = DST_C1;
                u.dst_idx = p;
            end else begin
                // conj(x_j*y_k - x_k*y_j), x = c0, y = c1
                p = 3'(g - GRP_CRS0);
                row = p[2:1];
                case (row)
                    2'd0: begin
                        j = 2'd1;
                        m = 2'd2;
                    end
                    2'd1: begin
                        j = 2'd2;
                        m = 2'd0;
                    end
                    default: begin
                        j = 2'd0;
                        m = 2'd1;
                    end
                endcase
                xjre = SRC_C0 + {2'b0, j, 1'b0};
                xjim = xjre + 5'd1;
                xkre = SRC_C0 + {2'b0, m, 1'b0};
                xkim = xkre + 5'd1;
                yjre = SRC_C1 + {2'b0, j, 1'b0};
                yjim = yjre + 5'd1;
                ykre = SRC_C1 + {2'b0, m, 1'b0};
                ykim = ykre + 5'd1;
                if (!p[0]) begin
                    case (k)
                        3'd0: begin u.a_sel = xjre; u.b_sel = ykre; u.neg = 1'b0; end
                        3'd1: begin u.a_sel = xjim; u.b_sel = ykim; u.neg = 1'b1; end
                        3'd2: begin u.a_sel = xkre; u.b_sel = yjre; u.neg = 1'b1; end
                        default: begin u.a_sel = xkim; u.b_sel = yjim; u.neg = 1'b0; end
                    endcase
                end else begin
                    case (k)
                        3'd0: begin u.a_sel = xjre; u.b_sel = ykim; u.neg = 1'b1; end
                        3'd1: begin u.a_sel = xjim; u.b_sel = ykre; u.neg = 1'b1; end
                        3'd2: begin u.a_sel = xkre; u.b_sel = yjim; u.neg = 1'b0; end
                        default: begin u.a_sel = xkim; u.b_sel = yjre; u.neg = 1'b0; end
                    endcase
                end
                u.dst = DST_C2;
                u.dst_idx = p;
            end
            return u;
        end
    endfunction

endpackage

@@ design/su3_gram_schmidt_projection.sv @@
`timescale 1ns / 1ps
// Channel   Ports                       Handshake                 Payload
// request   push, full, i_item          push & !full              sgs_pkg::t_in
// result    empty, pop, o_item          pop & !empty              sgs_pkg::t_out
//
// Per matrix the back end takes the request, runs 78 multiply ops in 16 op groups,
// each followed by a drain, plus the bit-serial norm root and the six-lane divider
// for each nonzero column, and hands the result over to the result buffer.
// A two-entry request queue and a three-column result buffer let both sides stall
// independently; the next matrix starts while results are still being popped.
// Reset is synchronous, active low, and clears only control state.
module su3_gram_schmidt_projection #(
    parameter int FRAC_BITS = sgs_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  sgs_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output sgs_pkg::t_out o_item
);

    sgs_pkg::t_in                q_item;
    logic                        q_vld, q_take;
    logic                        rt_start, rt_done, dv_start, dv_done;
    logic [sgs_pkg::SQ_W-1:0]    rt_sq;
    logic [sgs_pkg::RT_W-1:0]    rt_root, dv_den;
    sgs_pkg::t_col               dv_val, dv_quo;

    // request queue
    sgs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .o_vld   (q_vld),
        .i_take  (q_take),
        .o_item  (q_item)
    );

    // norm root
    sgs_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rt_start),
        .i_sq    (rt_sq),
        .o_done  (rt_done),
        .o_root  (rt_root)
    );

    // normalizing divider
    sgs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_den   (dv_den),
        .i_val   (dv_val),
        .o_done  (dv_done),
        .o_quo   (dv_quo)
    );

    // sequencer, datapath and result buffer
    sgs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (q_vld),
        .i_item     (q_item),
        .o_take     (q_take),
        .empty      (empty),
        .pop        (pop),
        .o_item     (o_item),
        .o_rt_start (rt_start),
        .o_rt_sq    (rt_sq),
        .i_rt_done  (rt_done),
        .i_rt_root  (rt_root),
        .o_dv_start (dv_start),
        .o_dv_den   (dv_den),
        .o_dv_val   (dv_val),
        .i_dv_done  (dv_done),
        .i_dv_quo   (dv_quo)
    );

endmodule

@@ design/sgs_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts matrix requests into a two-entry queue.
// Depends on sgs_pkg for the request type.
module sgs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  sgs_pkg::t_in  i_item,
    output logic          o_vld,
    input  logic          i_take,
    output sgs_pkg::t_in  o_item
);

    sgs_pkg::t_in r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         wr, rd;

    assign full   = (r_cnt == 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign o_item = r_mem[r_rp];
    assign wr     = push && !full;
    assign rd     = i_take && o_vld;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

@@ design/sgs_root.sv @@
`timescale 1ns / 1ps
// Bit-serial integer square root of a sum of squares scaled by 2^(2*guard).
// Depends on sgs_pkg for widths.
module sgs_root (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sgs_pkg::SQ_W-1:0]   i_sq,
    output logic                       o_done,
    output logic [sgs_pkg::RT_W-1:0]   o_root
);

    localparam int RT_W  = sgs_pkg::RT_W;
    localparam int RAD_W = 2 * RT_W;
    localparam int REM_W = RT_W + 3;
    localparam int CNT_W = $clog2(RT_W + 1);

    logic [RAD_W-1:0] r_rad;
    logic [REM_W-1:0] r_rem;
    logic [RT_W-1:0]  r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [REM_W-1:0] rem_sh, trial;
    logic             ge;

    // one root digit per cycle
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = REM_W'({r_root, 2'b01});
    assign ge     = (rem_sh >= trial);
    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= {i_sq, {(RAD_W - sgs_pkg::SQ_W){1'b0}}};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= ge ? rem_sh - trial : rem_sh;
            r_root <= {r_root[RT_W-2:0], ge};
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(RT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

@@ design/sgs_div.sv @@
`timescale 1ns / 1ps
// Six-lane restoring divider: each part scaled by 2^(F+guard) over the norm root,
// truncated toward zero and saturated to 32 bits. Depends on sgs_pkg.
module sgs_div #(
    parameter int FRAC_BITS = sgs_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sgs_pkg::RT_W-1:0]  i_den,
    input  sgs_pkg::t_col             i_val,
    output logic                      o_done,
    output sgs_pkg::t_col             o_quo
);

    localparam int RT_W  = sgs_pkg::RT_W;
    localparam int DW    = sgs_pkg::DW;
    localparam int NUM_W = DW + FRAC_BITS + sgs_pkg::NORM_GUARD;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [RT_W-1:0]  r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    assign o_done = r_done;

    // shared control: one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one lane per part
    for (genvar g = 0; g < 6; g++) begin : g_lane
        logic [DW-1:0]   r_mag;
        logic [RT_W-1:0] r_rem;
        logic [DW:0]     r_q;
        logic            r_ovf;
        logic            r_neg;
        logic [RT_W:0]   rem_sh;
        logic            ge;
        logic            big_pos, big_neg;

        assign rem_sh = {r_rem, r_mag[DW-1]};
        assign ge     = (rem_sh >= {1'b0, r_den});

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_neg <= i_val[g][DW-1];
                r_mag <= i_val[g][DW-1] ? (~i_val[g] + 1'b1) : i_val[g];
                r_rem <= '0;
                r_q   <= '0;
                r_ovf <= 1'b0;
            end else if (r_busy) begin
                r_mag <= {r_mag[DW-2:0], 1'b0};
                r_rem <= ge ? RT_W'(rem_sh - {1'b0, r_den}) : RT_W'(rem_sh);
                r_q   <= {r_q[DW-1:0], ge};
                r_ovf <= r_ovf | r_q[DW];
            end
        end

        // saturate to the signed 32-bit range
        assign big_pos = r_ovf || r_q[DW] || r_q[DW-1];
        assign big_neg = r_ovf || r_q[DW] || (r_q[DW-1] && (r_q[DW-2:0] != '0));

        always_comb begin
            if (r_neg) begin
                o_quo[g] = big_neg ? 32'h8000_0000 : (~r_q[DW-1:0] + 1'b1);
            end else begin
                o_quo[g] = big_pos ? 32'h7FFF_FFFF : r_q[DW-1:0];
            end
        end
    end

endmodule

@@ design/sgs_back.sv @@
`timescale 1ns / 1ps
// Back end: op sequencer with a shared multiply-accumulate datapath, norm control
// and the three-column result buffer. Depends on sgs_pkg, driven by sgs_root/sgs_div.
module sgs_back #(
    parameter int FRAC_BITS = sgs_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  sgs_pkg::t_in              i_item,
    output logic                      o_take,
    output logic                      empty,
    input  logic                      pop,
    output sgs_pkg::t_out             o_item,
    output logic                      o_rt_start,
    output logic [sgs_pkg::SQ_W-1:0]  o_rt_sq,
    input  logic                      i_rt_done,
    input  logic [sgs_pkg::RT_W-1:0]  i_rt_root,
    output logic                      o_dv_start,
    output logic [sgs_pkg::RT_W-1:0]  o_dv_den,
    output sgs_pkg::t_col             o_dv_val,
    input  logic                      i_dv_done,
    input  sgs_pkg::t_col             i_dv_quo
);

    localparam int ACC_W = sgs_pkg::ACC_W;
    localparam int MUL_W = sgs_pkg::MUL_W;
    localparam int P_W   = 2 * MUL_W;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_ROOT  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]  r_st, n_st;
    logic [3:0]  r_grp, n_grp;
    logic [2:0]  r_op, n_op;

    sgs_pkg::t_col r_c0, r_c1, r_c2;
    logic [63:0]   r_dre, r_dim;

    logic signed [P_W-1:0]   r_p;
    logic                    r_p_neg, r_p_clr, r_p_vld;
    logic [1:0]              r_p_sh;
    logic signed [ACC_W-1:0] r_acc, n_acc;

    sgs_pkg::t_col r_ob_c0, r_ob_c1, r_ob_c2;
    logic          r_ob_vld;
    logic [1:0]    r_ob_idx;

    sgs_pkg::t_uop           u;
    logic                    op_last, wb, ob_free, ob_load;
    logic signed [MUL_W-1:0] a_op, b_op;
    logic signed [ACC_W-1:0] term, base, rnd;
    logic [31:0]             sat32_v;
    logic [63:0]             sat64_v;
    sgs_pkg::t_col           col;

    // operand select from the working registers
    function automatic logic signed [MUL_W-1:0] opnd(
        input logic [4:0] s, input sgs_pkg::t_col c0, input sgs_pkg::t_col c1,
        input logic [63:0] dre, input logic [63:0] dim);
        logic signed [MUL_W-1:0] v;
        logic [4:0]              t;
        begin
            t = s - sgs_pkg::SRC_C1;
            case (s)
                sgs_pkg::SRC_DRE_LO: v = {1'b0, dre[31:0]};
                sgs_pkg::SRC_DRE_HI: v = {dre[63], dre[63:32]};
                sgs_pkg::SRC_DIM_LO: v = {1'b0, dim[31:0]};
                sgs_pkg::SRC_DIM_HI: v = {dim[63], dim[63:32]};
                sgs_pkg::SRC_ONE:    v = MUL_W'(1);
                default: begin
                    if (s < sgs_pkg::SRC_C1) begin
                        v = {c0[s[2:0]][31], c0[s[2:0]]};
                    end else begin
                        v = {c1[t[2:0]][31], c1[t[2:0]]};
                    end
                end
            endcase
            return v;
        end
    endfunction

    // current op and sequencing
    always_comb begin
        u       = sgs_pkg::uop_at(r_grp, r_op);
        op_last = (r_op == sgs_pkg::grp_last_op(r_grp));
        wb      = (r_st == ST_DRAIN) && !r_p_vld;
        ob_free = !r_ob_vld || (pop && r_ob_idx == sgs_pkg::COL_LAST);
        ob_load = (r_st == ST_DONE) && ob_free;
        n_st = r_st;
        n_grp = r_grp;
        n_op = r_op;
        o_take = 1'b0;
        o_rt_start = 1'b0;
        o_dv_start = 1'b0;
        case (r_st)
            ST_IDLE: begin
                if (i_vld) begin
                    o_take = 1'b1;
                    n_grp = sgs_pkg::GRP_SQ0;
                    n_op = '0;
                    n_st = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (op_last) begin
                    n_st = ST_DRAIN;
                end else begin
                    n_op = r_op + 3'd1;
                end
            end
            ST_DRAIN: begin
                if (!r_p_vld) begin
                    if (u.dst == sgs_pkg::DST_SUMSQ && r_acc != '0) begin
                        o_rt_start = 1'b1;
                        n_st = ST_ROOT;
                    end else if (r_grp == sgs_pkg::GRP_LAST) begin
                        n_st = ST_DONE;
                    end else begin
                        n_grp = r_grp + 4'd1;
                        n_op = '0;
                        n_st = ST_ISSUE;
                    end
                end
            end
            ST_ROOT: begin
                if (i_rt_done) begin
                    o_dv_start = 1'b1;
                    n_st = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_dv_done) begin
                    n_grp = r_grp + 4'd1;
                    n_op = '0;
                    n_st = ST_ISSUE;
                end
            end
            ST_DONE: begin
                if (ob_free) begin
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_grp <= '0;
            r_op  <= '0;
        end else begin
            r_st  <= n_st;
            r_grp <= n_grp;
            r_op  <= n_op;
        end
    end

    // multiplier stage
    assign a_op = opnd(u.a_sel, r_c0, r_c1, r_dre, r_dim);
    assign b_op = opnd(u.b_sel, r_c0, r_c1, r_dre, r_dim);

    always_ff @(posedge i_clk) begin
        r_p     <= a_op * b_op;
        r_p_neg <= u.neg;
        r_p_sh  <= u.sh;
        r_p_clr <= (r_op == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= (r_st == ST_ISSUE);
        end
    end

    // accumulate stage
    always_comb begin
        term = ACC_W'(r_p);
        case (r_p_sh)
            sgs_pkg::SH_32:   term = term <<< 32;
            sgs_pkg::SH_FRAC: term = term <<< FRAC_BITS;
            default:          term = term;
        endcase
        base  = r_p_clr ? '0 : r_acc;
        n_acc = r_p_neg ? base - term : base + term;
    end

    always_ff @(posedge i_clk) begin
        if (r_p_vld) begin
            r_acc <= n_acc;
        end
    end

    // round half up, then saturate
    assign rnd = (r_acc + HALF) >>> FRAC_BITS;

    always_comb begin
        if (&rnd[ACC_W-1:31] || ~|rnd[ACC_W-1:31]) begin
            sat32_v = rnd[31:0];
        end else begin
            sat32_v = rnd[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        if (&rnd[ACC_W-1:63] || ~|rnd[ACC_W-1:63]) begin
            sat64_v = rnd[63:0];
        end else begin
            sat64_v = rnd[ACC_W-1] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
    end

    // norm units
    assign o_rt_sq  = r_acc[sgs_pkg::SQ_W-1:0];
    assign o_dv_den = i_rt_root;
    assign o_dv_val = (r_grp == sgs_pkg::GRP_SQ0) ? r_c0 : r_c1;

    // working columns
    always_ff @(posedge i_clk) begin
        if (r_st == ST_IDLE && i_vld) begin
            r_c0 <= {i_item.a2_im, i_item.a2_re, i_item.a1_im,
                     i_item.a1_re, i_item.a0_im, i_item.a0_re};
            r_c1 <= {i_item.b2_im, i_item.b2_re, i_item.b1_im,
                     i_item.b1_re, i_item.b0_im, i_item.b0_re};
        end else if (r_st == ST_DIV && i_dv_done) begin
            if (r_grp == sgs_pkg::GRP_SQ0) begin
                r_c0 <= i_dv_quo;
            end else begin
                r_c1 <= i_dv_quo;
            end
        end else if (wb && u.dst == sgs_pkg::DST_C1) begin
            r_c1[u.dst_idx] <= sat32_v;
        end
        if (wb) begin
            case (u.dst)
                sgs_pkg::DST_DRE: r_dre <= sat64_v;
                sgs_pkg::DST_DIM: r_dim <= sat64_v;
                sgs_pkg::DST_C2:  r_c2[u.dst_idx] <= sat32_v;
                default: ;
            endcase
        end
    end

    // result buffer, drained one column per pop
    always_ff @(posedge i_clk) begin
        if (ob_load) begin
            r_ob_c0 <= r_c0;
            r_ob_c1 <= r_c1;
            r_ob_c2 <= r_c2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_vld <= 1'b0;
            r_ob_idx <= '0;
        end else if (ob_load) begin
            r_ob_vld <= 1'b1;
            r_ob_idx <= '0;
        end else if (pop && r_ob_vld) begin
            if (r_ob_idx == sgs_pkg::COL_LAST) begin
                r_ob_vld <= 1'b0;
                r_ob_idx <= '0;
            end else begin
                r_ob_idx <= r_ob_idx + 2'd1;
            end
        end
    end

    always_comb begin
        case (r_ob_idx)
            2'd0:    col = r_ob_c0;
            2'd1:    col = r_ob_c1;
            default: col = r_ob_c2;
        endcase
        o_item.column_index = r_ob_idx;
        o_item.r0_re = col[0];
        o_item.r0_im = col[1];
        o_item.r1_re = col[2];
        o_item.r1_im = col[3];
        o_item.r2_re = col[4];
        o_item.r2_im = col[5];
        o_item.last_column = (r_ob_idx == sgs_pkg::COL_LAST);
    end

    assign empty = !r_ob_vld;

endmodule
